// File: rtl/core/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared constants and types for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dbq_pkg;

   // queue depth, one cell per entry
   localparam int CAPACITY = 16;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PURGE      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // contents of one cell as seen by its neighbors
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] data;
   } cell_link_type;

   // shift and update strobes, already qualified by full and empty
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_back;
      logic pop_front;
      logic purge;
   } cell_ctl_type;

endpackage

// File: rtl/core/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit values built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the req_ stream (command and value in req_tdata) and
//   each gives exactly one result on the rsp_ stream (popped data, found,
//   is_empty and status in rsp_tdata).
//   Every command completes in the cycle it is accepted: all cells shift
//   together and compare against the value together, so one item per cycle
//   is sustained while the receiver takes results, and the registered result
//   shows on rsp_tvalid in the cycle after the item is accepted.
//   The result sits in an output register; req_tready stays high while that
//   register is empty or being drained, so a new item may be taken in the
//   same cycle the previous result is taken.
//   When the receiver stalls, the result holds and req_tready drops until
//   it is taken; the queue contents do not change meanwhile.
//   Reset empties the queue (all valid bits cleared) and drops rsp_tvalid.
//   A push when full reports status full, a pop when empty reports status
//   empty; neither changes the contents.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue import dbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[2:0], value[34:3], zero[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // data[31:0], found[32], is_empty[33],
                                    // status[35:34], zero[39:36]
);

   logic               accept;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;
   logic               full, empty;
   logic               push_ok;
   cell_ctl_type       ctl;

   cell_link_type      cell_out  [CAPACITY];
   logic [VALUE_W-1:0] cell_tail [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   logic [CAPACITY-1:0] cell_valid;

   logic [VALUE_W-1:0]  tail_data;
   logic [VALUE_W-1:0]  data_res;
   logic                found_res, empty_res;
   logic [STATUS_W-1:0] status_res;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // input handshake and field unpacking
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign command    = req_tdata[2:0];
   assign value      = req_tdata[34:3];

   // fill level from the valid thermometer
   assign empty = !cell_valid[0];
   assign full  = cell_valid[CAPACITY-1];

   // command decode, qualified by fill level
   always_comb begin
      ctl.push_back  = (command == CMD_PUSH_BACK)  && !full;
      ctl.push_front = (command == CMD_PUSH_FRONT) && !full;
      ctl.pop_back   = (command == CMD_POP_BACK)   && !empty;
      ctl.pop_front  = (command == CMD_POP_FRONT)  && !empty;
      ctl.purge      = (command == CMD_PURGE);
   end
   assign push_ok = ctl.push_back || ctl.push_front;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link, right_link;

      if (i == 0) begin : g_head
         assign left_link.valid = 1'b1;
         assign left_link.data  = value;
      end else begin : g_mid_left
         assign left_link = cell_out[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign right_link.valid = 1'b0;
         assign right_link.data  = '0;
      end else begin : g_mid_right
         assign right_link = cell_out[i+1];
      end

      dbq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .ctl       (ctl),
         .value     (value),
         .left      (left_link),
         .right     (right_link),
         .link      (cell_out[i]),
         .tail_data (cell_tail[i]),
         .match     (cell_match[i])
      );

      assign cell_valid[i] = cell_out[i].valid;
   end

   // back entry: only the last valid cell drives its tap
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_data = tail_data | cell_tail[i];
      end
   end

   // result fields
   always_comb begin
      data_res   = '0;
      found_res  = 1'b0;
      status_res = ST_OK;
      unique case (command)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (full) status_res = ST_FULL;
         end
         CMD_POP_BACK: begin
            if (empty) status_res = ST_EMPTY;
            else       data_res   = tail_data;
         end
         CMD_POP_FRONT: begin
            if (empty) status_res = ST_EMPTY;
            else       data_res   = cell_out[0].data;
         end
         CMD_FIND: begin
            found_res = |cell_match;
         end
         default: begin
         end
      endcase
   end

   // empty after this command
   assign empty_res = ctl.purge
                   || ((ctl.pop_back || ctl.pop_front) && !cell_valid[1])
                   || (empty && !push_ok);

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = data_res;
         rsp_found_in  = found_res;
         rsp_empty_in  = empty_res;
         rsp_status_in = status_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_empty_ff, rsp_found_ff, rsp_data_ff};

   // valid cells always form an unbroken run from the front
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("valid cells not contiguous from the front");

   // a front push lands the value in the head cell
   a_push_front: assert property (@(posedge clock) disable iff (reset)
      accept && ctl.push_front |=> cell_valid[0] && cell_out[0].data == $past(value))
      else $error("front push did not land in head cell");

   // purge leaves no valid cell
   a_purge: assert property (@(posedge clock) disable iff (reset)
      accept && ctl.purge |=> cell_valid == '0)
      else $error("purge left valid cells");

   // reported empty flag matches the cells after the command
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_empty_ff == !cell_valid[0])
      else $error("empty flag disagrees with cell contents");

endmodule

// File: rtl/core/dbq_cell.sv
// ----------------------------------------------------------------------------
// dbq_cell
// One storage cell of the queue chain: holds an entry and its valid bit,
// shifts toward either neighbor and compares against the search value.
// ----------------------------------------------------------------------------
module dbq_cell import dbq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] value,
   input  cell_link_type      left,     // cell toward the front
   input  cell_link_type      right,    // cell toward the back
   output cell_link_type      link,
   output logic [VALUE_W-1:0] tail_data,
   output logic               match
);

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] data_ff, data_in;

   // next cell contents
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         priority if (ctl.purge) begin
            valid_in = 1'b0;
         end else if (ctl.push_back) begin
            if (!valid_ff && left.valid) begin
               valid_in = 1'b1;
               data_in  = value;
            end
         end else if (ctl.push_front) begin
            valid_in = left.valid;
            data_in  = left.data;
         end else if (ctl.pop_front) begin
            valid_in = right.valid;
            data_in  = right.data;
         end else if (ctl.pop_back) begin
            if (valid_ff && !right.valid) begin
               valid_in = 1'b0;
            end
         end
      end
   end

   // valid bit under reset, entry data without
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // neighbor view, tail tap and search compare
   assign link.valid = valid_ff;
   assign link.data  = data_ff;
   assign tail_data  = (valid_ff && !right.valid) ? data_ff : '0;
   assign match      = valid_ff && (data_ff == value);

endmodule

// File: sim/dbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_checker
// Scoreboard for the bounded double-ended queue: it watches both streams,
// keeps its own copy of the queue contents, predicts one result for every
// accepted command and compares each returned result field by field.
// ----------------------------------------------------------------------------
module dbq_checker import dbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // command[2:0], value[34:3], zero[39:35]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // data[31:0], found[32], is_empty[33],
                                    // status[35:34], zero[39:36]
   output int          mismatch_count,
   output int          pending_count
);

   // one result item laid out as on rsp_tdata
   typedef struct packed {
      logic [3:0]          pad;
      logic [STATUS_W-1:0] status;
      logic                is_empty;
      logic                found;
      logic [VALUE_W-1:0]  data;
   } dbq_result_type;

   // shadow copy of the queue, front at cell 0
   logic [VALUE_W-1:0] shadow_cells [CAPACITY];
   int                 shadow_count = 0;

   dbq_result_type expected_results [$];
   int             fail_total = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // apply one command to the shadow queue and return its result
   function automatic dbq_result_type apply_command(input logic [CMD_W-1:0]   cmd,
                                                    input logic [VALUE_W-1:0] val);
      dbq_result_type res;
      res = '0;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_cells[shadow_count] = val;
               shadow_count++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[0] = val;
               shadow_count++;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_count--;
               res.data = shadow_cells[shadow_count];
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.data = shadow_cells[0];
               for (int i = 1; i < shadow_count; i++) shadow_cells[i-1] = shadow_cells[i];
               shadow_count--;
            end
         end
         CMD_FIND: begin
            // only valid cells take part in the search
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_cells[i] == val) res.found = 1'b1;
            end
         end
         CMD_PURGE: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      res.is_empty = (shadow_count == 0);
      return res;
   endfunction

   // count a bad result, print the first few in full
   task automatic report_mismatch(input string why, input dbq_result_type want,
                                  input dbq_result_type got);
      fail_total++;
      if (fail_total <= 10) begin
         $display("%0t mismatch (%s): data exp %h got %h, found exp %b got %b",
                  $realtime, why, want.data, got.data, want.found, got.found);
         $display("   is_empty exp %b got %b, status exp %0d got %0d, pad exp %h got %h",
                  want.is_empty, got.is_empty, want.status, got.status,
                  want.pad, got.pad);
      end
   endtask

   // compare returned items first, then predict the newly accepted command
   always @(posedge clock) begin
      dbq_result_type got;
      dbq_result_type want;
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               report_mismatch("no result expected", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) report_mismatch("wrong field", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_command(req_tdata[2:0], req_tdata[34:3]));
         end
      end
      mismatch_count <= fail_total;
      pending_count  <= expected_results.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the bounded double-ended queue: a directed pass over the empty,
// extreme-value and search corner cases, then random fill past full, drain and mixed
// sequences, with random gaps on both streams and a scoreboard checking every result.
// ----------------------------------------------------------------------------
module testbench import dbq_pkg::*;;

   // command codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int ITEM_TARGET    = 1150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 4;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int items_sent   = 0;
   int quiet_cycles = 0;
   bit no_idle      = 1'b0;

   // small value set so that searches often hit
   logic [VALUE_W-1:0] value_pool [8];

   always #5 clock = ~clock;

   bounded_double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dbq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return value_pool[$urandom_range(0, 7)];
      if (roll == 5) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // offer one item and return at the edge where it is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, cmd};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every result is back, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CMD_W-1:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return CMD_PUSH_BACK;
      if (roll < 50) return CMD_PUSH_FRONT;
      if (roll < 65) return CMD_POP_BACK;
      if (roll < 80) return CMD_POP_FRONT;
      if (roll < 94) return CMD_FIND;
      if (roll < 97) return CMD_PURGE;
      return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
   endfunction

   // one random sequence: fill past full, drain past empty, or a mix
   task automatic run_sequence();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         len = CAPACITY + $urandom_range(0, 3);
         repeat (len) send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                pick_value());
      end else if (kind < 4) begin
         len = CAPACITY + $urandom_range(0, 3);
         repeat (len) send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                $urandom);
      end else begin
         len = $urandom_range(12, 30);
         repeat (len) send_item(pick_command(), pick_value());
      end
   endtask

   // receiver: random stalls of the same shape as the sender gaps
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // end the run if neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int next_pause;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'h0000_0001;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h7FFF_FFFF;
      value_pool[4] = 32'h8000_0000;
      value_pool[5] = 32'h5A5A_5A5A;
      value_pool[6] = 32'h0000_0007;
      value_pool[7] = 32'hFFFF_0000;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue: refused pops, search, purge and unused codes
      send_item(CMD_POP_BACK,  $urandom);
      send_item(CMD_POP_FRONT, $urandom);
      send_item(CMD_FIND,      32'h0000_0000);
      send_item(CMD_PURGE,     $urandom);
      send_item(CMD_SPARE_LO,  $urandom);
      send_item(CMD_SPARE_HI,  $urandom);
      // extremes at both ends
      send_item(CMD_PUSH_BACK,  32'h7FFF_FFFF);
      send_item(CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(CMD_PUSH_BACK,  32'h0000_0000);
      send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(CMD_FIND,       32'h8000_0000);
      send_item(CMD_FIND,       32'h0001_2345);
      send_item(CMD_POP_FRONT,  $urandom);
      send_item(CMD_POP_BACK,   $urandom);
      // a popped value must no longer be found
      send_item(CMD_FIND,       32'h0000_0000);
      send_item(CMD_SPARE_HI,   32'hFFFF_FFFF);
      send_item(CMD_PURGE,      32'hFFFF_FFFF);
      send_item(CMD_FIND,       32'h7FFF_FFFF);
      wait_drained();

      // random sequences, with stretches of no idling and drain pauses
      next_pause = items_sent + 300;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
         if ($urandom_range(0, 7) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
         run_sequence();
         if (items_sent >= next_pause) begin
            wait_drained();
            next_pause = items_sent + 300;
         end
      end
      no_idle = 1'b0;
      wait_drained();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
